// ----- src/sevt_pkg.sv -----
// Shared sizes, command and status codes, and the stored entry type of the event table.
package sevt_pkg;

	localparam int CAPACITY  = 16;
	localparam int TIME_BITS = 32;
	localparam int TAG_BITS  = 8;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int REM_W     = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_QUERY  = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_LIST   = 2'd3
	} cmd_t;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

	typedef struct packed {
		logic [TAG_BITS-1:0]  tag;
		logic [TIME_BITS-1:0] st;
		logic [TIME_BITS-1:0] en;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- src/sevt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sevt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/sorted_event_table.sv -----
// Event table kept sorted by start time, one RAM entry visited per cycle by a sequencer
// while a list is not stalled by the output. Insert, query and delete each give one
// result; list streams one result per cycle. One command at a time is taken, and the
// scan walks the single RAM read port one entry a cycle. List stalls with the output.
// Reset clears the sequencer, the entry count and the output valid; RAM is not cleared.
module sorted_event_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [sevt_pkg::CMD_W-1:0]     cmd,
	input  logic [sevt_pkg::TAG_BITS-1:0]  event_tag,
	input  logic [sevt_pkg::TIME_BITS-1:0] start_time,
	input  logic [sevt_pkg::TIME_BITS-1:0] end_time,
	input  logic [sevt_pkg::TIME_BITS-1:0] now_time,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [sevt_pkg::STATUS_W-1:0]  status,
	output logic [sevt_pkg::TAG_BITS-1:0]  tag_out,
	output logic [sevt_pkg::TIME_BITS-1:0] start_out,
	output logic [sevt_pkg::TIME_BITS-1:0] end_out,
	output logic [sevt_pkg::REM_W-1:0]     removed_count,
	output logic                           last
);
	import sevt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_PLACE,
		S_RESP
	} state_t;

	state_t               state_q;
	cmd_t                 cmd_q;
	entry_t               new_q;
	logic [TIME_BITS-1:0] now_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     remain_q;
	logic [CNT_W-1:0]     keep_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     pidx_q;
	logic                 pend_q;
	logic [IDX_W-1:0]     place_q;

	logic [STATUS_W-1:0]  rs_status_q;
	entry_t               rs_entry_q;
	logic [REM_W-1:0]     rs_removed_q;

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	entry_t               out_entry_q;
	logic [REM_W-1:0]     removed_q;
	logic                 last_q;

	entry_t               rd_data;
	logic [ENTRY_W-1:0]   rd_bits;
	logic [IDX_W-1:0]     rd_addr;
	logic                 we;
	logic [IDX_W-1:0]     waddr;
	entry_t               wdata;

	logic                 out_free;
	logic                 hold;
	logic                 issue;
	logic                 is_last;
	logic                 ins_move;
	logic                 qry_hit;
	logic                 del_keep;
	logic [CNT_W-1:0]     keep_next;

	assign rd_data = entry_t'(rd_bits);

	sevt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(rd_addr),
		.rdata(rd_bits)
	);

	// compare the entry coming out of the RAM and pick the scan step
	always_comb begin
		out_free  = !out_valid_q || out_ready;
		hold      = (cmd_q == CMD_LIST) && pend_q && !out_free;
		rd_addr   = hold ? pidx_q : idx_q;
		issue     = (state_q == S_SCAN) && !hold && (remain_q != '0);
		is_last   = (remain_q == '0);
		ins_move  = rd_data.st >= new_q.st;
		qry_hit   = (rd_data.st <= now_q) && (rd_data.en >= now_q);
		del_keep  = rd_data.en >= now_q;
		keep_next = keep_q + CNT_W'(del_keep);
	end

	// drive the RAM write port: shift up on insert, pack down on delete, place new entry
	always_comb begin
		we    = 1'b0;
		waddr = pidx_q + 1'b1;
		wdata = rd_data;
		case (state_q)
			S_SCAN: begin
				if (pend_q && cmd_q == CMD_INSERT && ins_move) begin
					we = 1'b1;
				end else if (pend_q && cmd_q == CMD_DELETE && del_keep) begin
					we    = 1'b1;
					waddr = keep_q[IDX_W-1:0];
				end
			end
			S_PLACE: begin
				we    = 1'b1;
				waddr = place_q;
				wdata = new_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// sequencer, table count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			pend_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			cmd_q        <= CMD_INSERT;
			new_q        <= '0;
			now_q        <= '0;
			remain_q     <= '0;
			keep_q       <= '0;
			idx_q        <= '0;
			pidx_q       <= '0;
			place_q      <= '0;
			rs_status_q  <= ST_OK;
			rs_entry_q   <= '0;
			rs_removed_q <= '0;
			status_q     <= ST_OK;
			out_entry_q  <= '0;
			removed_q    <= '0;
			last_q       <= 1'b0;
		end else begin
			// drop the result once the consumer takes it
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q        <= cmd_t'(cmd);
						new_q        <= '{tag: event_tag, st: start_time, en: end_time};
						now_q        <= now_time;
						pend_q       <= 1'b0;
						keep_q       <= '0;
						remain_q     <= cnt_q;
						rs_entry_q   <= '0;
						rs_removed_q <= '0;
						if (cmd_t'(cmd) == CMD_INSERT) begin
							idx_q <= IDX_W'(cnt_q - 1'b1);
							if (cnt_q == CNT_W'(CAPACITY)) begin
								rs_status_q <= ST_FULL;
								state_q     <= S_RESP;
							end else if (cnt_q == '0) begin
								place_q <= '0;
								state_q <= S_PLACE;
							end else begin
								state_q <= S_SCAN;
							end
						end else begin
							idx_q <= '0;
							if (cnt_q == '0) begin
								rs_status_q <= (cmd_t'(cmd) == CMD_DELETE) ? ST_OK : ST_NONE;
								state_q     <= S_RESP;
							end else begin
								state_q <= S_SCAN;
							end
						end
					end
				end

				S_SCAN: begin
					if (!hold) begin
						// advance the read pointer
						pend_q <= issue;
						pidx_q <= idx_q;
						if (issue) begin
							remain_q <= remain_q - 1'b1;
							idx_q    <= (cmd_q == CMD_INSERT) ? idx_q - 1'b1 : idx_q + 1'b1;
						end
						// evaluate the entry read last cycle
						if (pend_q) begin
							case (cmd_q)
								CMD_INSERT: begin
									if (!ins_move) begin
										place_q <= pidx_q + 1'b1;
										state_q <= S_PLACE;
									end else if (is_last) begin
										place_q <= pidx_q;
										state_q <= S_PLACE;
									end
								end
								CMD_QUERY: begin
									if (qry_hit) begin
										rs_status_q <= ST_OK;
										rs_entry_q  <= rd_data;
										state_q     <= S_RESP;
									end else if (is_last) begin
										rs_status_q <= ST_NONE;
										state_q     <= S_RESP;
									end
								end
								CMD_DELETE: begin
									keep_q <= keep_next;
									if (is_last) begin
										cnt_q        <= keep_next;
										rs_status_q  <= ST_OK;
										rs_removed_q <= REM_W'(cnt_q - keep_next);
										state_q      <= S_RESP;
									end
								end
								default: begin
									// list: stream this entry out
									out_valid_q <= 1'b1;
									status_q    <= ST_OK;
									out_entry_q <= rd_data;
									removed_q   <= '0;
									last_q      <= is_last;
									if (is_last) begin
										state_q <= S_IDLE;
									end
								end
							endcase
						end
					end
				end

				S_PLACE: begin
					cnt_q       <= cnt_q + 1'b1;
					rs_status_q <= ST_OK;
					state_q     <= S_RESP;
				end

				S_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= rs_status_q;
						out_entry_q <= rs_entry_q;
						removed_q   <= rs_removed_q;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign tag_out       = out_entry_q.tag;
	assign start_out     = out_entry_q.st;
	assign end_out       = out_entry_q.en;
	assign removed_count = removed_q;
	assign last          = last_q;

endmodule
